/* rtl/cnesf_pkg.sv */
// ----------------------------------------------------------------------------
// cnesf_pkg
// Shared types and fixed constants of the cross-neighbor extremum finder.
// ----------------------------------------------------------------------------
package cnesf_pkg;

	localparam int ROW_BITS        = 16;
	localparam int CFG_WIDTH_BITS  = 13;
	localparam int CFG_HEIGHT_BITS = 16;
	localparam int CFG_DATA_BITS   = 16;
	localparam int MIN_DIM         = 3;
	localparam int WIDTH_RESET     = 4096;
	localparam int HEIGHT_RESET    = 4096;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CLS_MINIMUM  = 2'd0,
		CLS_MAXIMUM  = 2'd1,
		CLS_SADDLE_A = 2'd2,
		CLS_SADDLE_B = 2'd3
	} point_class_t;

	typedef struct packed {
		logic         hit;
		point_class_t cls;
	} class_res_t;

endpackage

/* rtl/cross_neighbor_extremum_saddle_finder.sv */
// ----------------------------------------------------------------------------
// cross_neighbor_extremum_saddle_finder
// Raster-order local minimum, maximum and saddle detector on cross neighbors.
// ----------------------------------------------------------------------------
// The block takes one signed fixed-point pixel per beat on the slave stream
// and sustains one pixel per clock: each pixel costs exactly one read and one
// write of the line memory, which has one port of each kind, and the result
// path is a two-entry output buffer, so the slave side stalls only when both
// output entries are full. The pixel arriving at (column c, row r) is the
// lower neighbor of center (c, r-1); the center is checked against its left,
// right, upper and lower neighbors and reported through the output buffer
// when all four differences are positive (minimum), all negative
// (maximum), left/right positive with up/down negative (saddle A) or the
// reverse (saddle B). Equal values never match, borders are never reported.
// Column and row counters wrap at the programmed width and height, so frames
// follow one another without tuser; tuser set on a beat forces it to column 0,
// row 0. The line memory has no reset and no clearing pass: it is valid once
// two full rows have streamed in, which is also the first row with reports.
// Write image_width (index 0) and image_height (index 1) only while idle;
// width is clamped to [3, MAX_WIDTH] and height to at least 3.
// ----------------------------------------------------------------------------
module cross_neighbor_extremum_saddle_finder import cnesf_pkg::*; #(
	parameter int MAX_WIDTH   = 4096,
	parameter int PIXEL_BITS  = 32,
	localparam int CW           = $clog2(MAX_WIDTH),
	localparam int DIFF_BITS    = PIXEL_BITS + 1,
	localparam int IN_TDATA_W   = ((PIXEL_BITS + 7) / 8) * 8,
	localparam int OUT_FIELDS_W = CW + ROW_BITS + PIXEL_BITS + 4 * DIFF_BITS,
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_TDATA_W-1:0]    s_tdata,   // pixel_value
	input  logic                     s_tuser,   // frame_start
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// column, row, center_value, diff_next_col, diff_prev_col,
	// diff_next_row, diff_prev_row
	output logic [OUT_TDATA_W-1:0]   m_tdata,
	output logic [1:0]               m_tuser,   // point_class
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [0:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int WW = CW + 1;
	localparam int WIDTH_RESET_USED = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	// configuration, held already clamped
	logic [WW-1:0]       width_used_q;
	logic [ROW_BITS-1:0] height_used_q;
	logic [31:0]         width_req;
	logic [WW-1:0]       width_new;
	logic [ROW_BITS-1:0] height_req;
	logic [ROW_BITS-1:0] height_new;

	// position counters and accept-side decode
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic                s_acc;
	logic                en;
	logic [CW-1:0]       c_in;
	logic [ROW_BITS-1:0] r_in;
	logic [WW-1:0]       c_inc;
	logic                c_wrap;
	logic [CW-1:0]       c_next;
	logic [ROW_BITS:0]   r_inc;
	logic [ROW_BITS-1:0] r_next;
	logic [WW:0]         c_plus2;
	logic                in_pos;

	// stage 1
	logic                  v_s1;
	logic                  chk_s1;
	logic [CW-1:0]         col_s1;
	logic [ROW_BITS-1:0]   row_s1;
	logic [PIXEL_BITS-1:0] pix_s1;

	// window: entry of the center column and left center
	logic [2*PIXEL_BITS-1:0] cur_q;
	logic [PIXEL_BITS-1:0]   win0_q;
	logic [2*PIXEL_BITS-1:0] mem_rd;

	logic [DIFF_BITS-1:0]  d_right;
	logic [DIFF_BITS-1:0]  d_left;
	logic [DIFF_BITS-1:0]  d_down;
	logic [DIFF_BITS-1:0]  d_up;
	class_res_t            res;

	logic                    buf_in_valid;
	logic [OUT_FIELDS_W-1:0] buf_in_data;
	logic [OUT_FIELDS_W-1:0] buf_out_data;
	point_class_t            buf_out_class;
	logic [CW-1:0]           m_column;

	// ------------------------------------------------------------------
	// configuration port: always ready, clamp on the way in
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_comb begin
		width_req = 32'(cfg_data[CFG_WIDTH_BITS-1:0]);
		if (width_req < 32'(MIN_DIM)) begin
			width_new = WW'(MIN_DIM);
		end else if (width_req > 32'(MAX_WIDTH)) begin
			width_new = WW'(MAX_WIDTH);
		end else begin
			width_new = WW'(width_req);
		end
		height_req = cfg_data[CFG_HEIGHT_BITS-1:0];
		height_new = (height_req < ROW_BITS'(MIN_DIM)) ? ROW_BITS'(MIN_DIM) : height_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_used_q  <= WW'(WIDTH_RESET_USED);
			height_used_q <= ROW_BITS'(HEIGHT_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: begin
					width_used_q <= width_new;
				end
				REG_IMAGE_HEIGHT: begin
					height_used_q <= height_new;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// accept side: position of the arriving pixel and the next column,
	// which is also the line memory address read for the right neighbor
	// ------------------------------------------------------------------
	assign en       = s_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign c_in     = s_tuser ? '0 : col_q;
	assign r_in     = s_tuser ? '0 : row_q;
	assign c_inc    = {1'b0, c_in} + WW'(1);
	assign c_wrap   = (c_inc >= width_used_q);
	assign c_next   = c_wrap ? '0 : c_inc[CW-1:0];
	assign r_inc    = {1'b0, r_in} + (ROW_BITS + 1)'(1);
	assign r_next   = (r_inc >= {1'b0, height_used_q}) ? '0 : r_inc[ROW_BITS-1:0];
	assign c_plus2  = {2'b00, c_in} + (WW + 1)'(2);
	// center must have both row neighbors and both column neighbors in frame
	assign in_pos   = (r_in >= ROW_BITS'(2)) && (r_in < height_used_q) &&
		(c_in != '0) && (c_plus2 <= {1'b0, width_used_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			v_s1   <= 1'b0;
			win0_q <= '0;
		end else begin
			if (s_acc) begin
				col_q <= c_next;
				row_q <= c_wrap ? r_next : r_in;
			end
			if (en) begin
				v_s1 <= s_acc;
			end
			// advance the window as the pixel leaves stage 1
			if (en && v_s1) begin
				win0_q <= cur_q[PIXEL_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			pix_s1 <= s_tdata[PIXEL_BITS-1:0];
			col_s1 <= c_in;
			row_s1 <= r_in;
			chk_s1 <= in_pos;
		end
		// word read for the right neighbor becomes the next center column
		if (en && v_s1) begin
			cur_q <= mem_rd;
		end
	end

	// ------------------------------------------------------------------
	// line memory: word = {row r-2, row r-1} of one column
	// roll on write: previous row drops to far, new pixel goes to near
	// ------------------------------------------------------------------
	cnesf_line_mem #(
		.DEPTH (MAX_WIDTH),
		.DW    (2 * PIXEL_BITS)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_acc),
		.rd_addr (c_next),
		.rd_data (mem_rd),
		.wr_en   (en && v_s1),
		.wr_addr (col_s1),
		.wr_data ({cur_q[PIXEL_BITS-1:0], pix_s1})
	);

	cnesf_classify #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_classify (
		.center     (cur_q[PIXEL_BITS-1:0]),
		.right_nb   (mem_rd[PIXEL_BITS-1:0]),
		.left_nb    (win0_q),
		.down_nb    (pix_s1),
		.up_nb      (cur_q[2*PIXEL_BITS-1:PIXEL_BITS]),
		.diff_right (d_right),
		.diff_left  (d_left),
		.diff_down  (d_down),
		.diff_up    (d_up),
		.res        (res)
	);

	// ------------------------------------------------------------------
	// result beat: drop non-matching and border centers
	// ------------------------------------------------------------------
	assign buf_in_valid = v_s1 && chk_s1 && res.hit;
	assign buf_in_data  = {d_up, d_down, d_left, d_right, cur_q[PIXEL_BITS-1:0],
		ROW_BITS'(row_s1 - ROW_BITS'(1)), col_s1};

	cnesf_out_buf #(
		.DW (OUT_FIELDS_W)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (buf_in_valid),
		.in_data   (buf_in_data),
		.in_class  (res.cls),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (buf_out_data),
		.out_class (buf_out_class)
	);

	assign m_tdata  = OUT_TDATA_W'(buf_out_data);
	assign m_tuser  = buf_out_class;
	assign m_column = buf_out_data[CW-1:0];

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tuser |=> v_s1 && (col_s1 == '0) && (row_s1 == '0))
		else $error("frame start did not restart the position counters");

	a_no_border: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_column != '0) && ({1'b0, m_column} + WW'(2) <= width_used_q))
		else $error("border column reported");

endmodule

/* rtl/cnesf_line_mem.sv */
// ----------------------------------------------------------------------------
// cnesf_line_mem
// Line memory holding the two previous rows per column, one read and one
// write port, registered read with bypass of a same-edge write.
// ----------------------------------------------------------------------------
module cnesf_line_mem #(
	parameter int DEPTH = 4096,
	parameter int DW    = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] ram_q [DEPTH];
	logic [DW-1:0] rd_q;
	logic [DW-1:0] fwd_data_q;
	logic          fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= ram_q[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// the array read sees the old word when the write lands on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
		else $error("line memory bypass returned stale data");

endmodule

/* rtl/cnesf_classify.sv */
// ----------------------------------------------------------------------------
// cnesf_classify
// Four neighbor-minus-center differences and the point class they imply.
// ----------------------------------------------------------------------------
module cnesf_classify import cnesf_pkg::*; #(
	parameter int PIXEL_BITS = 32,
	localparam int DIFF_BITS = PIXEL_BITS + 1
) (
	input  logic [PIXEL_BITS-1:0] center,
	input  logic [PIXEL_BITS-1:0] right_nb,
	input  logic [PIXEL_BITS-1:0] left_nb,
	input  logic [PIXEL_BITS-1:0] down_nb,
	input  logic [PIXEL_BITS-1:0] up_nb,
	output logic [DIFF_BITS-1:0]  diff_right,
	output logic [DIFF_BITS-1:0]  diff_left,
	output logic [DIFF_BITS-1:0]  diff_down,
	output logic [DIFF_BITS-1:0]  diff_up,
	output class_res_t            res
);

	logic [DIFF_BITS-1:0] ct_x;
	logic [3:0]           pos;
	logic [3:0]           neg;

	// sign-extend by one bit so the difference is exact
	assign ct_x       = {center[PIXEL_BITS-1], center};
	assign diff_right = {right_nb[PIXEL_BITS-1], right_nb} - ct_x;
	assign diff_left  = {left_nb[PIXEL_BITS-1], left_nb} - ct_x;
	assign diff_down  = {down_nb[PIXEL_BITS-1], down_nb} - ct_x;
	assign diff_up    = {up_nb[PIXEL_BITS-1], up_nb} - ct_x;

	// bit order: right, left, down, up
	assign neg = {diff_up[DIFF_BITS-1], diff_down[DIFF_BITS-1],
		diff_left[DIFF_BITS-1], diff_right[DIFF_BITS-1]};
	assign pos = {!diff_up[DIFF_BITS-1] && (diff_up != '0),
		!diff_down[DIFF_BITS-1] && (diff_down != '0),
		!diff_left[DIFF_BITS-1] && (diff_left != '0),
		!diff_right[DIFF_BITS-1] && (diff_right != '0)};

	always_comb begin
		res.hit = 1'b1;
		res.cls = CLS_MINIMUM;
		priority if (pos == 4'b1111) begin
			res.cls = CLS_MINIMUM;
		end else if (neg == 4'b1111) begin
			res.cls = CLS_MAXIMUM;
		end else if (pos[1:0] == 2'b11 && neg[3:2] == 2'b11) begin
			res.cls = CLS_SADDLE_A;
		end else if (neg[1:0] == 2'b11 && pos[3:2] == 2'b11) begin
			res.cls = CLS_SADDLE_B;
		end else begin
			res.hit = 1'b0;
		end
	end

endmodule

/* rtl/cnesf_out_buf.sv */
// ----------------------------------------------------------------------------
// cnesf_out_buf
// Output register with a skid stage so the upstream ready is registered.
// ----------------------------------------------------------------------------
module cnesf_out_buf import cnesf_pkg::*; #(
	parameter int DW = 192
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [DW-1:0] in_data,
	input  point_class_t in_class,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [DW-1:0] out_data,
	output point_class_t out_class
);

	logic         out_v_q;
	logic         skid_v_q;
	logic [DW-1:0] out_data_q;
	logic [DW-1:0] skid_data_q;
	point_class_t out_class_q;
	point_class_t skid_class_q;
	logic         load_from_skid;
	logic         load_from_in;
	logic         load_skid;

	assign in_ready       = !skid_v_q;
	assign load_from_skid = skid_v_q && out_ready;
	assign load_skid      = !skid_v_q && in_valid && out_v_q && !out_ready;
	assign load_from_in   = !skid_v_q && in_valid && !(out_v_q && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_from_skid) begin
				skid_v_q <= 1'b0;
			end else if (load_skid) begin
				skid_v_q <= 1'b1;
			end
			if (load_from_skid || load_from_in) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_from_skid) begin
			out_data_q  <= skid_data_q;
			out_class_q <= skid_class_q;
		end else if (load_from_in) begin
			out_data_q  <= in_data;
			out_class_q <= in_class;
		end
		if (load_skid) begin
			skid_data_q  <= in_data;
			skid_class_q <= in_class;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_data_q;
	assign out_class = out_class_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a beat while the output register is empty");

endmodule
